>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/bph_pkg.sv
// ----------------------------------------------------------------------------
// bph_pkg
// types and constants shared by the position history modules
// ----------------------------------------------------------------------------
`default_nettype none

package bph_pkg;

  localparam int POS_W   = 31;
  localparam int LIMIT_W = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

  typedef enum logic [1:0] {
    OP_SAVE  = 2'd0,
    OP_BACK  = 2'd1,
    OP_FWD   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // control strobes from the navigation logic to the entry store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

`default_nettype wire

>>> sv/bph_store.sv
// ----------------------------------------------------------------------------
// bph_store
// ring store of saved positions, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bph_store #(
  parameter int STORE_DEPTH = 128,
  parameter int SLOT_W      = $clog2(STORE_DEPTH)
) (
  input  wire                            clk,
  input  wire bph_pkg::store_ctl_t       ctl,
  input  wire [SLOT_W-1:0]               wr_addr,
  input  wire [bph_pkg::POS_W-1:0]       wr_data,
  input  wire [SLOT_W-1:0]               rd_addr,
  output logic [bph_pkg::POS_W-1:0]      rd_data
);
  import bph_pkg::*;

  logic [POS_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/bph_nav.sv
// ----------------------------------------------------------------------------
// bph_nav
// history state, neighbor cache and single-pass update for one item
// ----------------------------------------------------------------------------
`default_nettype none

module bph_nav #(
  parameter int STORE_DEPTH = 128,
  parameter int SLOT_W      = $clog2(STORE_DEPTH)
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            step,
  input  wire bph_pkg::op_t              op,
  input  wire [bph_pkg::POS_W-1:0]       pos,
  input  wire [bph_pkg::LIMIT_W-1:0]     limit,
  input  wire [bph_pkg::POS_W-1:0]       rd_data,
  output logic                           res_valid,
  output logic [bph_pkg::POS_W-1:0]      res_pos,
  output bph_pkg::store_ctl_t            store_ctl,
  output logic [SLOT_W-1:0]              wr_addr,
  output logic [bph_pkg::POS_W-1:0]      wr_data,
  output logic [SLOT_W-1:0]              rd_addr
);
  import bph_pkg::*;

  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W = (CNT_W + 1 > LIMIT_W) ? CNT_W + 1 : LIMIT_W;

  localparam logic [CNT_W:0]   DEPTH_C   = (CNT_W + 1)'(STORE_DEPTH);
  localparam logic [CNT_W:0]   ONE_C     = (CNT_W + 1)'(1);
  localparam logic [CNT_W:0]   TWO_C     = (CNT_W + 1)'(2);
  localparam logic [CNT_W:0]   ZERO_C    = '0;
  localparam logic [CMP_W-1:0] LIM_MAX_C = CMP_W'(STORE_DEPTH);
  localparam logic [CMP_W-1:0] LIM_MIN_C = CMP_W'(1);

  // ring index arithmetic: a is a slot, b is at most the depth plus one
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                  input logic [CNT_W:0] b);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(a) + b;
    if (sum >= DEPTH_C) begin
      sum = sum - DEPTH_C;
    end
    return sum[SLOT_W-1:0];
  endfunction

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [SLOT_W-1:0] offset;
  logic [SLOT_W-1:0] offset_next;
  logic [SLOT_W-1:0] oldest;
  logic [SLOT_W-1:0] oldest_next;
  logic [POS_W-1:0]  cur_value;
  logic [POS_W-1:0]  cur_value_next;
  logic [POS_W-1:0]  prev_value;
  logic [POS_W-1:0]  prev_value_next;
  logic [POS_W-1:0]  next_value;
  logic [POS_W-1:0]  next_value_next;
  logic              prev_pend;
  logic              prev_pend_next;
  logic              next_pend;
  logic              next_pend_next;

  logic              has_entries;
  logic [POS_W-1:0]  prev_eff;
  logic [POS_W-1:0]  next_eff;
  logic [CNT_W:0]    off_w;
  logic [CNT_W:0]    cnt_w;
  logic [CMP_W-1:0]  lim_ext;
  logic [CNT_W:0]    eff_lim;
  logic              can_back;
  logic              can_fwd;
  logic              save_skip;
  logic [CNT_W:0]    base;
  logic [CNT_W:0]    new_cnt;
  logic              drop;
  logic [CNT_W:0]    save_cnt;

  assign has_entries = (count != '0);
  // neighbor values come from the store's read register in the cycle after their read
  assign prev_eff    = prev_pend ? rd_data : prev_value;
  assign next_eff    = next_pend ? rd_data : next_value;
  assign off_w       = (CNT_W + 1)'(offset);
  assign cnt_w       = (CNT_W + 1)'(count);

  always_comb begin
    lim_ext = CMP_W'(limit);
    if (lim_ext < LIM_MIN_C) begin
      lim_ext = LIM_MIN_C;
    end else if (lim_ext > LIM_MAX_C) begin
      lim_ext = LIM_MAX_C;
    end
  end
  assign eff_lim = (CNT_W + 1)'(lim_ext);

  assign can_back  = has_entries && (offset != '0);
  assign can_fwd   = has_entries && ((off_w + ONE_C) < cnt_w);
  assign save_skip = has_entries && (cur_value == pos);

  // entries after the current one are discarded before the append
  assign base     = has_entries ? off_w + ONE_C : ZERO_C;
  assign new_cnt  = base + ONE_C;
  assign drop     = new_cnt > eff_lim;
  assign save_cnt = drop ? eff_lim : new_cnt;

  always_comb begin
    count_next      = count;
    offset_next     = offset;
    oldest_next     = oldest;
    cur_value_next  = cur_value;
    prev_value_next = prev_value;
    next_value_next = next_value;
    prev_pend_next  = prev_pend;
    next_pend_next  = next_pend;
    res_valid       = 1'b0;
    res_pos         = prev_eff;
    store_ctl       = '0;
    wr_addr         = slot_add(oldest, base);
    wr_data         = pos;
    rd_addr         = slot_add(oldest, off_w + TWO_C);
    if (step) begin
      unique case (op)
        OP_SAVE: begin
          if (!save_skip) begin
            store_ctl.wr_en = 1'b1;
            count_next      = save_cnt[CNT_W-1:0];
            offset_next     = SLOT_W'(save_cnt - ONE_C);
            oldest_next     = drop ? slot_add(oldest, new_cnt - eff_lim) : oldest;
            cur_value_next  = pos;
            prev_value_next = cur_value;
            prev_pend_next  = 1'b0;
            next_pend_next  = 1'b0;
          end
        end
        OP_BACK: begin
          if (can_back) begin
            res_valid       = 1'b1;
            res_pos         = prev_eff;
            offset_next     = offset - SLOT_W'(1);
            cur_value_next  = prev_eff;
            next_value_next = cur_value;
            next_pend_next  = 1'b0;
            prev_pend_next  = off_w >= TWO_C;
            store_ctl.rd_en = off_w >= TWO_C;
            rd_addr         = slot_add(oldest, off_w - TWO_C);
          end
        end
        OP_FWD: begin
          if (can_fwd) begin
            res_valid       = 1'b1;
            res_pos         = next_eff;
            offset_next     = offset + SLOT_W'(1);
            cur_value_next  = next_eff;
            prev_value_next = cur_value;
            prev_pend_next  = 1'b0;
            next_pend_next  = (off_w + TWO_C) < cnt_w;
            store_ctl.rd_en = (off_w + TWO_C) < cnt_w;
            rd_addr         = slot_add(oldest, off_w + TWO_C);
          end
        end
        OP_CLEAR: begin
          count_next     = '0;
          offset_next    = '0;
          oldest_next    = '0;
          prev_pend_next = 1'b0;
          next_pend_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      offset    <= '0;
      oldest    <= '0;
      prev_pend <= 1'b0;
      next_pend <= 1'b0;
    end else begin
      count     <= count_next;
      offset    <= offset_next;
      oldest    <= oldest_next;
      prev_pend <= prev_pend_next;
      next_pend <= next_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_value  <= cur_value_next;
    prev_value <= prev_value_next;
    next_value <= next_value_next;
  end

endmodule

`default_nettype wire

>>> sv/bounded_position_history.sv
// a result of a back or forward passes through the item register, then the result register
// throughput: one item per cycle while the result register drains; a stalled
//   result holds the item register, and with it the input
// the current entry and its two neighbors sit in registers, so a neighbor read
//   from the store lands in its read register before the next item needs it
// reset empties the history and sets the limit to 100; no clearing pass
// ----------------------------------------------------------------------------
// bounded_position_history
// back/forward history of saved positions kept in a bounded ring store
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_position_history #(
  parameter int STORE_DEPTH = 128
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            history_limit_we,
  input  wire [bph_pkg::LIMIT_W-1:0]     history_limit,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire [1:0]                      operation,
  input  wire [bph_pkg::POS_W-1:0]       position,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [bph_pkg::POS_W-1:0]      recalled_position
);
  import bph_pkg::*;

  localparam int SLOT_W = $clog2(STORE_DEPTH);

  logic [LIMIT_W-1:0] hist_limit;
  logic               item_valid;
  op_t                item_op;
  logic [POS_W-1:0]   item_pos;
  logic               proceed;
  logic               res_valid;
  logic [POS_W-1:0]   res_pos;
  store_ctl_t         store_ctl;
  logic [SLOT_W-1:0]  wr_addr;
  logic [POS_W-1:0]   wr_data;
  logic [SLOT_W-1:0]  rd_addr;
  logic [POS_W-1:0]   rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_limit <= LIMIT_RESET;
    end else if (history_limit_we) begin
      hist_limit <= history_limit;
    end
  end

  // the item register advances only when the result register can take a result
  assign proceed  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_op  <= op_t'(operation);
      item_pos <= position;
    end
  end

  bph_nav #(
    .STORE_DEPTH (STORE_DEPTH),
    .SLOT_W      (SLOT_W)
  ) u_nav (
    .clk       (clk),
    .rst       (rst),
    .step      (proceed),
    .op        (item_op),
    .pos       (item_pos),
    .limit     (hist_limit),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_pos   (res_pos),
    .store_ctl (store_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr)
  );

  bph_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .SLOT_W      (SLOT_W)
  ) u_store (
    .clk     (clk),
    .ctl     (store_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && res_valid) begin
      recalled_position <= res_pos;
    end
  end

endmodule

`default_nettype wire

>>> sv/bph_checker.sv
// ----------------------------------------------------------------------------
// bph_checker
// port-level checks on the position history, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bph_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [bph_pkg::POS_W-1:0]    recalled_position
);

  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(recalled_position), "result changed while stalled")
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result present after reset")
  `ASSERT_CLK(a_back_pressure, clk, rst, !in_ready |-> out_valid && !out_ready, "input stalled without a stalled result")
  // a fresh result comes from a transferred item via the item register, then the result register
  `ASSERT_CLK(a_result_source, clk, rst, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a prior input transfer")

endmodule

bind bounded_position_history bph_checker u_bph_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .recalled_position (recalled_position)
);

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks bounded_position_history against a cycle-free history model: saves,
// back/forward recalls and clears go through random phases of history_limit,
// with random idling on both sides and every recalled position compared
// ----------------------------------------------------------------------------

module testbench;
  import bph_pkg::*;

  localparam int              DEPTH       = 128;
  localparam logic [7:0]      DEPTH_MAX   = 8'd128;
  localparam int              CYCLE_LIMIT = 200000;
  localparam int              QUIET_WAIT  = 8;
  localparam int              DRAIN_BOUND = 1000;

  typedef struct {
    op_t               op;
    logic [POS_W-1:0]  pos;
  } history_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                history_limit_we = 1'b0;
  logic [LIMIT_W-1:0]  history_limit = '0;
  logic                in_valid = 1'b0;
  wire                 in_ready;
  logic [1:0]          operation = '0;
  logic [POS_W-1:0]    position = '0;
  wire                 out_valid;
  logic                out_ready = 1'b0;
  wire  [POS_W-1:0]    recalled_position;

  bounded_position_history #(.STORE_DEPTH(DEPTH)) dut (
    .clk               (clk),
    .rst               (rst),
    .history_limit_we  (history_limit_we),
    .history_limit     (history_limit),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation         (operation),
    .position          (position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .recalled_position (recalled_position)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // history model state
  logic [POS_W-1:0]    saved_pos [DEPTH];
  logic [6:0]          hist_oldest;
  logic [7:0]          hist_count;
  logic [6:0]          hist_cur;
  logic [7:0]          kept_limit;

  history_item_t       pending_items[$];
  logic [POS_W-1:0]    recall_q[$];
  logic [POS_W-1:0]    last_saved = '0;

  int                  in_idle_pct = 0;
  int                  out_idle_pct = 0;
  int                  error_count = 0;
  int                  recall_count = 0;
  int                  op_count [4] = '{0, 0, 0, 0};
  int                  cycle_count = 0;

  function automatic logic [6:0] ring_slot(logic [7:0] offset);
    return hist_oldest + offset[6:0];
  endfunction

  function automatic logic [7:0] clamp_limit(logic [7:0] raw);
    if (raw == 8'd0) return 8'd1;
    if (raw > DEPTH_MAX) return DEPTH_MAX;
    return raw;
  endfunction

  task automatic clear_history();
    hist_oldest = '0;
    hist_count  = '0;
    hist_cur    = '0;
  endtask

  task automatic apply_history_op(op_t op, logic [POS_W-1:0] pos);
    logic [7:0] lim;
    case (op)
      OP_SAVE: begin
        // same position as the current entry leaves the history alone
        if (!(hist_count != 8'd0 && saved_pos[ring_slot({1'b0, hist_cur})] == pos)) begin
          if (hist_count != 8'd0) hist_count = {1'b0, hist_cur} + 8'd1;
          saved_pos[ring_slot(hist_count)] = pos;
          hist_count = hist_count + 8'd1;
          lim = clamp_limit(kept_limit);
          if (hist_count > lim) begin
            hist_oldest = ring_slot(hist_count - lim);
            hist_count  = lim;
          end
          hist_cur = 7'(hist_count - 8'd1);
        end
      end
      OP_BACK: begin
        if (hist_count != 8'd0 && hist_cur != 7'd0) begin
          hist_cur = hist_cur - 7'd1;
          recall_q.push_back(saved_pos[ring_slot({1'b0, hist_cur})]);
        end
      end
      OP_FWD: begin
        if (hist_count != 8'd0 && ({1'b0, hist_cur} + 8'd1) < hist_count) begin
          hist_cur = hist_cur + 7'd1;
          recall_q.push_back(saved_pos[ring_slot({1'b0, hist_cur})]);
        end
      end
      default: begin
        clear_history();
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    history_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        it = pending_items.pop_front();
        in_valid  <= 1'b1;
        operation <= it.op;
        position  <= it.pos;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predicts on input transfers, checks on output transfers
  always @(posedge clk) begin
    logic [POS_W-1:0] want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        apply_history_op(op_t'(operation), position);
        op_count[operation] = op_count[operation] + 1;
      end
      if (out_valid && out_ready) begin
        recall_count = recall_count + 1;
        if (recall_q.size() == 0) begin
          error_count = error_count + 1;
          $display("%0t: unexpected result: expected none, got %0d", $time, recalled_position);
        end else begin
          want = recall_q.pop_front();
          if (recalled_position !== want) begin
            error_count = error_count + 1;
            $display("%0t: recalled_position mismatch: expected %0d, got %0d",
                     $time, want, recalled_position);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_item(op_t op, logic [POS_W-1:0] pos);
    history_item_t it;
    it.op  = op;
    it.pos = pos;
    pending_items.push_back(it);
    if (op == OP_SAVE) last_saved = pos;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int          r;
    logic [31:0] raw;
    r   = $urandom_range(99);
    raw = $urandom;
    // repeats of the last save hit the ignore path, small values collide
    if (r < 15) return last_saved;
    if (r < 35) return POS_W'($urandom_range(0, 15));
    return raw[POS_W-1:0];
  endfunction

  // all issued, all results back, then a quiet gap for trailing saves
  task automatic wait_idle();
    int n;
    n = 0;
    do @(negedge clk); while (pending_items.size() != 0 || in_valid);
    while (recall_q.size() != 0 && n < DRAIN_BOUND) begin
      @(negedge clk);
      n = n + 1;
    end
    while (recall_q.size() != 0) begin
      error_count = error_count + 1;
      $display("%0t: missing result: expected %0d, got none", $time, recall_q.pop_front());
    end
    repeat (QUIET_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    @(posedge clk);
    history_limit_we <= 1'b1;
    history_limit    <= v;
    @(posedge clk);
    history_limit_we <= 1'b0;
    kept_limit = v;
  endtask

  task automatic queue_random(int n, int fill);
    int left;
    int kind;
    int len;
    int b;
    left = n;
    // long save run so the ring wraps and the limit bites
    repeat (fill) begin
      push_item(OP_SAVE, pick_position());
      left = left - 1;
    end
    while (left > 0) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len && left > 0; i++) begin
          push_item(OP_SAVE, pick_position());
          left = left - 1;
        end
      end else if (kind < 88) begin
        b   = $urandom_range(1, 10);
        len = $urandom_range(0, b + 2);
        for (int i = 0; i < b && left > 0; i++) begin
          push_item(OP_BACK, pick_position());
          left = left - 1;
        end
        for (int i = 0; i < len && left > 0; i++) begin
          push_item(OP_FWD, pick_position());
          left = left - 1;
        end
      end else if (kind < 92) begin
        push_item(OP_CLEAR, pick_position());
        left = left - 1;
      end else begin
        push_item(op_t'($urandom_range(0, 3)), pick_position());
        left = left - 1;
      end
    end
  endtask

  initial begin
    logic [7:0] phase_limit [8];
    int         phase_fill [8];
    string      limits_seen;
    for (int i = 0; i < DEPTH; i++) saved_pos[i] = '0;
    clear_history();
    kept_limit = LIMIT_RESET;
    phase_limit = '{8'd1, 8'd0, 8'd128, 8'd2, 8'd255, 8'd127,
                    8'($urandom_range(3, 126)), 8'd100};
    phase_fill  = '{0, 0, 135, 0, 135, 0, 0, 0};
    limits_seen = "100";

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    in_idle_pct  = 22;
    out_idle_pct = 69;

    // directed: empty history, ignore path, both ends, truncation, clear
    push_item(OP_BACK,  31'h7FFF_FFFF);
    push_item(OP_FWD,   31'h0);
    push_item(OP_SAVE,  31'h0);
    push_item(OP_SAVE,  31'h0);
    push_item(OP_SAVE,  31'h7FFF_FFFF);
    push_item(OP_SAVE,  31'h2AAA_AAAA);
    push_item(OP_SAVE,  31'h5555_5555);
    push_item(OP_BACK,  31'h0);
    push_item(OP_BACK,  31'h0);
    push_item(OP_BACK,  31'h0);
    push_item(OP_BACK,  31'h0);
    push_item(OP_FWD,   31'h0);
    push_item(OP_FWD,   31'h0);
    push_item(OP_FWD,   31'h0);
    push_item(OP_FWD,   31'h0);
    push_item(OP_BACK,  31'h0);
    push_item(OP_SAVE,  31'h0000_0001);
    push_item(OP_FWD,   31'h0);
    push_item(OP_BACK,  31'h0);
    push_item(OP_CLEAR, 31'h7FFF_FFFF);
    push_item(OP_BACK,  31'h0);
    push_item(OP_SAVE,  31'h0000_0005);
    push_item(OP_SAVE,  31'h0000_0005);
    push_item(OP_BACK,  31'h0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        in_idle_pct  = 69;
        out_idle_pct = 22;
      end else if (p == 6) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      write_limit(phase_limit[p]);
      limits_seen = $sformatf("%s %0d", limits_seen, phase_limit[p]);
      queue_random(phase_fill[p] + 76, phase_fill[p]);
      wait_idle();
    end

    $display("run covered %0d saves, %0d backs, %0d forwards, %0d clears; %0d recalls checked",
             op_count[OP_SAVE], op_count[OP_BACK], op_count[OP_FWD], op_count[OP_CLEAR],
             recall_count);
    $display("limits used: %s; three idling profiles, %0d errors", limits_seen, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/bph_pkg.sv
sv/bph_store.sv
sv/bph_nav.sv
sv/bounded_position_history.sv
sv/bph_checker.sv
dv/testbench.sv
